// ===== hw/rtl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared widths, constants, register map and types of the touch-programmed
// light sequencer.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int SEQ_STEPS   = 100;
   localparam int IDX_W       = $clog2(SEQ_STEPS + 1);
   localparam int PAT_ADDR_W  = (SEQ_STEPS > 1) ? $clog2(SEQ_STEPS) : 1;

   localparam int LEVEL_W     = 16;
   localparam int CNT_W       = 8;
   localparam int THR_W       = 10;
   localparam int SHIFT_W     = 4;
   localparam int FILT_W      = 32;
   localparam int CMP_W       = 18;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WARMUP_TICKS      = 3'd0,
      REG_DETECT_THRESHOLD  = 3'd1,
      REG_DETECT_HYSTERESIS = 3'd2,
      REG_IDLE_SHIFT        = 3'd3,
      REG_TOUCHED_SHIFT     = 3'd4,
      REG_STEP_DIVIDER      = 3'd5,
      REG_COUNTDOWN_LENGTH  = 3'd6
   } reg_index_type;

   localparam logic [CNT_W-1:0]   RST_WARMUP_TICKS      = 8'd40;
   localparam logic [THR_W-1:0]   RST_DETECT_THRESHOLD  = 10'd20;
   localparam logic [THR_W-1:0]   RST_DETECT_HYSTERESIS = 10'd5;
   localparam logic [SHIFT_W-1:0] RST_IDLE_SHIFT        = 4'd6;
   localparam logic [SHIFT_W-1:0] RST_TOUCHED_SHIFT     = 4'd10;
   localparam logic [CNT_W-1:0]   RST_STEP_DIVIDER      = 8'd2;
   localparam logic [CNT_W-1:0]   RST_COUNTDOWN_LENGTH  = 8'd30;

   localparam logic [1:0] HIST_FRESH_TOUCH = 2'b01;

   typedef struct packed {
      logic [CNT_W-1:0]   warmup_ticks;
      logic [THR_W-1:0]   detect_threshold;
      logic [THR_W-1:0]   detect_hysteresis;
      logic [SHIFT_W-1:0] idle_filter_shift;
      logic [SHIFT_W-1:0] touched_filter_shift;
      logic [CNT_W-1:0]   step_divider;
      logic [CNT_W-1:0]   countdown_length;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
   } head_type;

endpackage

// ===== hw/rtl/plt_if.sv =====
// ----------------------------------------------------------------------------
// plt_if
// Valid/ready channels of the sequencer: measurement items in, result items
// out.
// ----------------------------------------------------------------------------
interface plt_req_if
   import plt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] capture_count;

   modport source (output valid, output capture_count, input ready);
   modport sink   (input valid, input capture_count, output ready);
endinterface

interface plt_rsp_if
   import plt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               led_on;
   logic               touched;
   logic               programming;
   logic [LEVEL_W-1:0] baseline_level;

   modport source (output valid, output led_on, output touched, output programming,
                   output baseline_level, input ready);
   modport sink   (input valid, input led_on, input touched, input programming,
                   input baseline_level, output ready);
endinterface

// ===== hw/rtl/plt_ram.sv =====
// ----------------------------------------------------------------------------
// plt_ram
// Generic single-write, single-read RAM with registered read data
// (read-first on a same-address collision).
// ----------------------------------------------------------------------------
module plt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/plt_csr.sv =====
// ----------------------------------------------------------------------------
// plt_csr
// APB-style configuration registers of the sequencer.
// ----------------------------------------------------------------------------
module plt_csr
   import plt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WARMUP_TICKS:      cfg_in.warmup_ticks         = csr_pwdata[CNT_W-1:0];
            REG_DETECT_THRESHOLD:  cfg_in.detect_threshold     = csr_pwdata[THR_W-1:0];
            REG_DETECT_HYSTERESIS: cfg_in.detect_hysteresis    = csr_pwdata[THR_W-1:0];
            REG_IDLE_SHIFT:        cfg_in.idle_filter_shift    = csr_pwdata[SHIFT_W-1:0];
            REG_TOUCHED_SHIFT:     cfg_in.touched_filter_shift = csr_pwdata[SHIFT_W-1:0];
            REG_STEP_DIVIDER:      cfg_in.step_divider         = csr_pwdata[CNT_W-1:0];
            REG_COUNTDOWN_LENGTH:  cfg_in.countdown_length     = csr_pwdata[CNT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_WARMUP_TICKS:      csr_prdata[CNT_W-1:0]   = cfg_ff.warmup_ticks;
         REG_DETECT_THRESHOLD:  csr_prdata[THR_W-1:0]   = cfg_ff.detect_threshold;
         REG_DETECT_HYSTERESIS: csr_prdata[THR_W-1:0]   = cfg_ff.detect_hysteresis;
         REG_IDLE_SHIFT:        csr_prdata[SHIFT_W-1:0] = cfg_ff.idle_filter_shift;
         REG_TOUCHED_SHIFT:     csr_prdata[SHIFT_W-1:0] = cfg_ff.touched_filter_shift;
         REG_STEP_DIVIDER:      csr_prdata[CNT_W-1:0]   = cfg_ff.step_divider;
         REG_COUNTDOWN_LENGTH:  csr_prdata[CNT_W-1:0]   = cfg_ff.countdown_length;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_ticks         <= RST_WARMUP_TICKS;
         cfg_ff.detect_threshold     <= RST_DETECT_THRESHOLD;
         cfg_ff.detect_hysteresis    <= RST_DETECT_HYSTERESIS;
         cfg_ff.idle_filter_shift    <= RST_IDLE_SHIFT;
         cfg_ff.touched_filter_shift <= RST_TOUCHED_SHIFT;
         cfg_ff.step_divider         <= RST_STEP_DIVIDER;
         cfg_ff.countdown_length     <= RST_COUNTDOWN_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/plt_front.sv =====
// ----------------------------------------------------------------------------
// plt_front
// Input side: accepts measurement items into a short queue that decouples
// the request channel from the tracking and sequencing back end.
// ----------------------------------------------------------------------------
module plt_front
   import plt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   plt_req_if.sink  req_ch,
   input  logic     pop,
   output head_type head
);

   logic [LEVEL_W-1:0] data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;

   assign req_ch.ready = ~reset & (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid & req_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= req_ch.capture_count;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.level = data_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count lost a pop");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/plt_back.sv =====
// ----------------------------------------------------------------------------
// plt_back
// Back end: baseline tracking, touch detection and the record / playback
// sequencer, one item per cycle into a result register unless it is stalled.
// ----------------------------------------------------------------------------
module plt_back
   import plt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  head_type  head,
   output logic      pop,
   plt_rsp_if.source rsp_ch
);

   logic [LEVEL_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]   settle_ff, settle_in;
   logic [1:0]         hist_ff, hist_in;
   logic [CNT_W-1:0]   blink_ff, blink_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   vote_ff, vote_in;
   logic [IDX_W-1:0]   play_ff, play_in;
   logic [IDX_W-1:0]   rec_ff, rec_in;

   logic               out_valid_ff, out_valid_in;
   logic               led_ff, led_in;
   logic               touched_ff, touched_in;
   logic               prog_ff, prog_in;
   logic [LEVEL_W-1:0] out_base_ff, out_base_in;

   logic [SEQ_STEPS-1:0]  pat_vld_ff, pat_vld_in;
   logic                  vld_rd_ff;
   logic                  fwd_hit_ff;
   logic                  fwd_bit_ff;
   logic                  pat_we;
   logic [PAT_ADDR_W-1:0] pat_waddr;
   logic                  pat_wbit;
   logic [PAT_ADDR_W-1:0] pat_raddr;
   logic [0:0]            pat_rdata;
   logic                  pat_bit;

   logic [LEVEL_W-1:0]   level;
   logic                 was_touched;
   logic                 now_touched;
   logic [SHIFT_W-1:0]   shift;
   logic [FILT_W-1:0]    filt_shl;
   logic [FILT_W-1:0]    filt_sum;
   logic [FILT_W-1:0]    filt_out;
   logic [LEVEL_W-1:0]   base_new;
   logic signed [CMP_W-1:0] diff;
   logic signed [CMP_W-1:0] limit;
   logic [CNT_W-1:0]     step_nxt;
   logic [CNT_W-1:0]     vote_nxt;
   logic [IDX_W-1:0]     play_eff;
   logic [IDX_W-1:0]     play_inc;

   assign level       = head.level;
   assign was_touched = hist_ff[0];
   assign pop         = head.valid & (~out_valid_ff | rsp_ch.ready);

   // baseline filter: (b*(2^s-1) + level) >> s without a multiplier
   assign shift    = was_touched ? cfg.touched_filter_shift : cfg.idle_filter_shift;
   assign filt_shl = {{(FILT_W-LEVEL_W){1'b0}}, base_ff} << shift;
   assign filt_sum = filt_shl - {{(FILT_W-LEVEL_W){1'b0}}, base_ff}
                   + {{(FILT_W-LEVEL_W){1'b0}}, level};
   assign filt_out = filt_sum >> shift;

   always_comb begin
      if (settle_ff < cfg.warmup_ticks) begin
         base_new = level;
      end else if (level < filt_out[LEVEL_W-1:0]) begin
         base_new = level;
      end else begin
         base_new = filt_out[LEVEL_W-1:0];
      end
   end

   assign diff  = $signed({{(CMP_W-LEVEL_W){1'b0}}, level})
                - $signed({{(CMP_W-LEVEL_W){1'b0}}, base_new});
   assign limit = was_touched
                ? $signed({{(CMP_W-THR_W){1'b0}}, cfg.detect_threshold})
                  - $signed({{(CMP_W-THR_W){1'b0}}, cfg.detect_hysteresis})
                : $signed({{(CMP_W-THR_W){1'b0}}, cfg.detect_threshold})
                  + $signed({{(CMP_W-THR_W){1'b0}}, cfg.detect_hysteresis});
   assign now_touched = (diff > limit);

   assign step_nxt = step_ff + 1'b1;
   assign vote_nxt = vote_ff + {{(CNT_W-1){1'b0}}, now_touched};
   assign play_eff = (play_ff >= IDX_W'(SEQ_STEPS)) ? '0 : play_ff;
   assign play_inc = play_eff + 1'b1;

   assign pat_bit  = fwd_hit_ff ? fwd_bit_ff : (vld_rd_ff & pat_rdata[0]);

   always_comb begin
      base_in      = base_ff;
      settle_in    = settle_ff;
      hist_in      = hist_ff;
      blink_in     = blink_ff;
      step_in      = step_ff;
      vote_in      = vote_ff;
      play_in      = play_ff;
      rec_in       = rec_ff;
      led_in       = led_ff;
      touched_in   = touched_ff;
      prog_in      = prog_ff;
      out_base_in  = out_base_ff;
      pat_we       = 1'b0;
      pat_waddr    = rec_ff[PAT_ADDR_W-1:0];
      pat_wbit     = (vote_nxt > {1'b0, cfg.step_divider[CNT_W-1:1]});
      out_valid_in = out_valid_ff & ~rsp_ch.ready;

      if (pop) begin
         base_in = base_new;
         if (settle_ff < cfg.warmup_ticks) begin
            settle_in = settle_ff + 1'b1;
         end
         hist_in = {hist_ff[0], now_touched};

         priority if (blink_ff != '0) begin
            led_in   = blink_ff[0];
            blink_in = blink_ff - 1'b1;
         end else if (rec_ff < IDX_W'(SEQ_STEPS)) begin
            led_in = now_touched;
            if (step_nxt >= cfg.step_divider) begin
               step_in = '0;
               vote_in = '0;
               rec_in  = rec_ff + 1'b1;
               pat_we  = 1'b1;
            end else begin
               step_in = step_nxt;
               vote_in = vote_nxt;
            end
         end else if ({hist_ff[0], now_touched} == HIST_FRESH_TOUCH) begin
            blink_in = cfg.countdown_length;
            rec_in   = '0;
            play_in  = '0;
            step_in  = '0;
            led_in   = 1'b0;
         end else begin
            led_in = pat_bit;
            if (step_nxt >= cfg.step_divider) begin
               step_in = '0;
               play_in = (play_inc >= IDX_W'(SEQ_STEPS)) ? '0 : play_inc;
            end else begin
               step_in = step_nxt;
               play_in = play_eff;
            end
         end

         touched_in   = now_touched;
         prog_in      = (blink_in != '0) || (rec_in < IDX_W'(SEQ_STEPS));
         out_base_in  = base_new;
         out_valid_in = 1'b1;
      end
   end

   // prefetch the pattern bit for the play position the next item will see
   assign pat_raddr = (play_in >= IDX_W'(SEQ_STEPS)) ? '0 : play_in[PAT_ADDR_W-1:0];

   always_comb begin
      pat_vld_in = pat_vld_ff;
      if (pat_we) begin
         pat_vld_in[pat_waddr] = 1'b1;
      end
   end

   plt_ram #(
      .WIDTH (1),
      .DEPTH (SEQ_STEPS)
   ) u_pattern (
      .clock (clock),
      .we    (pat_we),
      .waddr (pat_waddr),
      .wdata (pat_wbit),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         settle_ff    <= '0;
         hist_ff      <= '0;
         blink_ff     <= '0;
         step_ff      <= '0;
         vote_ff      <= '0;
         play_ff      <= '0;
         rec_ff       <= IDX_W'(SEQ_STEPS);
         out_valid_ff <= 1'b0;
         pat_vld_ff   <= '0;
         vld_rd_ff    <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         base_ff      <= base_in;
         settle_ff    <= settle_in;
         hist_ff      <= hist_in;
         blink_ff     <= blink_in;
         step_ff      <= step_in;
         vote_ff      <= vote_in;
         play_ff      <= play_in;
         rec_ff       <= rec_in;
         out_valid_ff <= out_valid_in;
         pat_vld_ff   <= pat_vld_in;
         vld_rd_ff    <= pat_vld_ff[pat_raddr];
         fwd_hit_ff   <= pat_we && (pat_waddr == pat_raddr);
      end
   end

   always_ff @(posedge clock) begin
      fwd_bit_ff  <= pat_wbit;
      led_ff      <= led_in;
      touched_ff  <= touched_in;
      prog_ff     <= prog_in;
      out_base_ff <= out_base_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.led_on         = led_ff;
   assign rsp_ch.touched        = touched_ff;
   assign rsp_ch.programming    = prog_ff;
   assign rsp_ch.baseline_level = out_base_ff;

   assert property (@(posedge clock) disable iff (reset)
      (blink_ff != '0) |-> (rec_ff == '0))
      else $error("countdown running while recording has advanced");

   assert property (@(posedge clock) disable iff (reset)
      (rec_ff <= IDX_W'(SEQ_STEPS)) && (play_ff < IDX_W'(SEQ_STEPS)))
      else $error("sequence index out of range");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> (out_valid_ff && (hist_ff[1] == $past(hist_ff[0]))))
      else $error("processed item lost or touch history not shifted");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> (touched_ff == hist_ff[0]) && (out_base_ff == base_ff))
      else $error("result register disagrees with tracker state");

endmodule

// ===== hw/rtl/touch_programmed_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// touch_programmed_light_sequencer
// Capacitive touch detector with baseline tracking that records and plays
// back a 1-bit light sequence.
//
// One measurement item is taken per clock and gives one result item; the
// sustained rate is one item per cycle, set by the combinational baseline
// filter and touch compare, whose state feeds the next item. An item's
// result is registered: an accepted item is written into the input queue,
// then processed from the head of the queue into the result register, from
// which it is taken. A stalled result holds the back end; the two-entry
// input queue then fills and the request side stalls. The sequence store is
// a RAM with registered read whose entries read as zero until written
// (per-entry valid flags cleared by reset), so no clearing pass is needed
// and items are accepted right after reset. Configuration is over an
// APB-style port, registers at byte address 4*index; the user must write
// them only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_programmed_light_sequencer
   import plt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   plt_req_if.sink               req_ch,
   plt_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   head_type head;
   logic     pop;

   plt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   plt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   plt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== test/tb_touch_programmed_light_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_programmed_light_sequencer
// Self-checking bench for the touch-programmed light sequencer. Capture
// counts are streamed in with random gaps and output stalls. A cycle-free
// predictor tracks the baseline, the touch state and the record/playback
// sequencer, and every result item is compared field by field. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_touch_programmed_light_sequencer;
   import plt_pkg::*;

   typedef struct packed {
      logic               led_on;
      logic               touched;
      logic               programming;
      logic [LEVEL_W-1:0] baseline_level;
   } light_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   plt_req_if level_ch ();
   plt_rsp_if light_ch ();

   touch_programmed_light_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (level_ch),
      .rsp_ch      (light_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus and expectations
   logic [LEVEL_W-1:0] levels_pending[$];
   light_result_type   light_results_due[$];
   logic               level_taken;
   int                 sender_gap_pct;
   int                 receiver_stall_pct;
   int                 mismatch_count;
   int                 items_accepted;
   int                 settings_applied;
   int                 fresh_touches;
   int                 steps_recorded;

   // predictor state
   cfg_type            light_cfg;
   logic [LEVEL_W-1:0] base_track;
   logic [CNT_W-1:0]   settle_ticks;
   logic [1:0]         touch_hist;
   logic [CNT_W-1:0]   blink_left;
   logic [CNT_W-1:0]   step_ticks;
   logic [CNT_W-1:0]   vote_tally;
   logic               pattern_bits [SEQ_STEPS];
   int                 play_pos;
   int                 record_pos;

   always #5 clock = ~clock;

   task automatic predict_light_tick(input logic [LEVEL_W-1:0] level);
      light_result_type res;
      logic             was_touched;
      logic             touch_now;
      logic             led;
      logic [3:0]       shift;
      logic [63:0]      acc;
      int               diff;
      int               limit;
      int               thr;
      int               hyst;
      was_touched = touch_hist[0];
      if (settle_ticks < light_cfg.warmup_ticks) begin
         base_track   = level;
         settle_ticks = settle_ticks + 1'b1;
      end else begin
         shift      = was_touched ? light_cfg.touched_filter_shift
                                  : light_cfg.idle_filter_shift;
         acc        = (64'(base_track) * ((64'd1 << shift) - 64'd1) + 64'(level)) >> shift;
         base_track = acc[LEVEL_W-1:0];
         if (level < base_track)
            base_track = level;
      end

      thr   = int'({22'd0, light_cfg.detect_threshold});
      hyst  = int'({22'd0, light_cfg.detect_hysteresis});
      diff  = int'({16'd0, level}) - int'({16'd0, base_track});
      limit = was_touched ? thr - hyst : thr + hyst;
      touch_now  = (diff > limit);
      touch_hist = {touch_hist[0], touch_now};

      led = 1'b0;
      if (blink_left != 0) begin
         led        = blink_left[0];
         blink_left = blink_left - 1'b1;
      end else if (record_pos < SEQ_STEPS) begin
         led        = touch_now;
         vote_tally = vote_tally + {7'd0, touch_now};
         step_ticks = step_ticks + 1'b1;
         if (step_ticks >= light_cfg.step_divider) begin
            step_ticks               = '0;
            pattern_bits[record_pos] = (vote_tally > (light_cfg.step_divider >> 1));
            record_pos++;
            vote_tally = '0;
            steps_recorded++;
         end
      end else if (touch_hist == HIST_FRESH_TOUCH) begin
         blink_left = light_cfg.countdown_length;
         record_pos = 0;
         play_pos   = 0;
         step_ticks = '0;
         fresh_touches++;
      end else begin
         if (play_pos >= SEQ_STEPS)
            play_pos = 0;
         led        = pattern_bits[play_pos];
         step_ticks = step_ticks + 1'b1;
         if (step_ticks >= light_cfg.step_divider) begin
            step_ticks = '0;
            play_pos++;
            if (play_pos >= SEQ_STEPS)
               play_pos = 0;
         end
      end

      res.led_on         = led;
      res.touched        = touch_now;
      res.programming    = (blink_left != 0) || (record_pos < SEQ_STEPS);
      res.baseline_level = base_track;
      light_results_due.push_back(res);
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         level_ch.valid <= 1'b0;
         light_ch.ready <= 1'b0;
      end else begin
         if (!level_ch.valid || level_taken) begin
            if (levels_pending.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
               level_ch.valid         <= 1'b1;
               level_ch.capture_count <= levels_pending[0];
            end else begin
               level_ch.valid         <= 1'b0;
               level_ch.capture_count <= LEVEL_W'($urandom);
            end
         end
         light_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // monitor: handshakes sampled on the rising edge
   always @(posedge clock) begin
      level_taken <= !reset && level_ch.valid && level_ch.ready;
      if (!reset) begin
         if (light_ch.valid && light_ch.ready) begin
            if (light_results_due.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatch_count++;
            end else begin
               light_result_type want;
               want = light_results_due.pop_front();
               compare_field("led_on", want.led_on, light_ch.led_on);
               compare_field("touched", want.touched, light_ch.touched);
               compare_field("programming", want.programming, light_ch.programming);
               compare_field("baseline_level", want.baseline_level, light_ch.baseline_level);
            end
         end
         if (level_ch.valid && level_ch.ready) begin
            predict_light_tick(level_ch.capture_count);
            void'(levels_pending.pop_front());
            items_accepted++;
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic wait_drained();
      while (levels_pending.size() != 0 || light_results_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic cfg_type make_settings(input int start, input int thr, input int hyst,
                                             input int idle_sh, input int touch_sh,
                                             input int divider, input int countdown);
      cfg_type c;
      c.warmup_ticks         = CNT_W'(start);
      c.detect_threshold     = THR_W'(thr);
      c.detect_hysteresis    = THR_W'(hyst);
      c.idle_filter_shift    = SHIFT_W'(idle_sh);
      c.touched_filter_shift = SHIFT_W'(touch_sh);
      c.step_divider         = CNT_W'(divider);
      c.countdown_length     = CNT_W'(countdown);
      return c;
   endfunction

   task automatic apply_settings(input cfg_type c);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_write(REG_WARMUP_TICKS, CSR_DATA_W'(c.warmup_ticks));
      csr_write(REG_DETECT_THRESHOLD, CSR_DATA_W'(c.detect_threshold));
      csr_write(REG_DETECT_HYSTERESIS, CSR_DATA_W'(c.detect_hysteresis));
      csr_write(REG_IDLE_SHIFT, CSR_DATA_W'(c.idle_filter_shift));
      csr_write(REG_TOUCHED_SHIFT, CSR_DATA_W'(c.touched_filter_shift));
      csr_write(REG_STEP_DIVIDER, CSR_DATA_W'(c.step_divider));
      csr_write(REG_COUNTDOWN_LENGTH, CSR_DATA_W'(c.countdown_length));
      light_cfg = c;
      settings_applied++;
   endtask

   // quiet stretches near a resting level, touch pulses above the
   // threshold, and some full-range noise
   task automatic queue_touch_trace(input int count, input int quiet);
      int made;
      int len;
      int amp;
      int lvl;
      made = 0;
      amp  = int'({22'd0, light_cfg.detect_threshold})
           + int'({22'd0, light_cfg.detect_hysteresis});
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 3);
            if (len > count - made)
               len = count - made;
            repeat (len) levels_pending.push_back(LEVEL_W'($urandom));
            made += len;
         end else begin
            len = $urandom_range(1, 12);
            if (len > count - made)
               len = count - made;
            repeat (len) levels_pending.push_back(LEVEL_W'(quiet + $urandom_range(0, 3)));
            made += len;
            len = $urandom_range(1, 25);
            if (len > count - made)
               len = count - made;
            repeat (len) begin
               lvl = quiet + amp + $urandom_range(1, 600);
               if (lvl > 65535)
                  lvl = 65535;
               levels_pending.push_back(LEVEL_W'(lvl));
            end
            made += len;
         end
      end
   endtask

   task automatic run_phase(input cfg_type c, input int count, input int quiet,
                            input int gap_pct, input int stall_pct);
      apply_settings(c);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      queue_touch_trace(count / 2, quiet);
      // hold the sender back until the block has drained
      wait_drained();
      queue_touch_trace(count - count / 2, quiet);
   endtask

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      level_ch.valid         = 1'b0;
      level_ch.capture_count = '0;
      light_ch.ready         = 1'b0;
      level_taken            = 1'b0;
      sender_gap_pct         = 9;
      receiver_stall_pct     = 88;
      mismatch_count         = 0;
      items_accepted         = 0;
      settings_applied       = 0;
      fresh_touches          = 0;
      steps_recorded         = 0;

      light_cfg = make_settings(RST_WARMUP_TICKS, RST_DETECT_THRESHOLD, RST_DETECT_HYSTERESIS,
                                RST_IDLE_SHIFT, RST_TOUCHED_SHIFT, RST_STEP_DIVIDER,
                                RST_COUNTDOWN_LENGTH);
      base_track   = '0;
      settle_ticks = '0;
      touch_hist   = '0;
      blink_left   = '0;
      step_ticks   = '0;
      vote_tally   = '0;
      play_pos     = 0;
      record_pos   = SEQ_STEPS;
      foreach (pattern_bits[i]) pattern_bits[i] = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero touched shift, zero step divider, zero countdown,
      // hysteresis above threshold, extremes of the level
      apply_settings(make_settings(2, 10, 30, 15, 0, 0, 0));
      levels_pending = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                         16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE, 16'h0000, 16'h04D2,
                         16'h0FF0, 16'hF00F, 16'h3333, 16'hCCCC, 16'h0000, 16'hFFFF,
                         16'h1234, 16'h0000};

      run_phase(make_settings(0, 40, 10, 4, 8, 1, 3), 110, 3000, 9, 88);
      run_phase(make_settings(255, 1023, 1023, 1, 1, 255, 255), 60, 60000, 88, 9);
      run_phase(make_settings(5, 0, 1023, 15, 15, 3, 1), 80, 20000, 88, 9);
      run_phase(make_settings(40, 20, 5, 6, 10, 2, 30), 100, 500, 0, 0);
      run_phase(make_settings(1, 1023, 0, 2, 3, 1, 0), 80, 10000, 0, 0);

      wait_drained();
      repeat (4) @(posedge clock);
      $display("Run covered %0d capture items under %0d register settings,", items_accepted,
               settings_applied);
      $display("with %0d fresh touches and %0d sequence steps recorded.", fresh_touches,
               steps_recorded);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout: %0d results still expected", light_results_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
